/* rtl/sta_pkg.sv */
// package for the slot table aligned allocator
// item and control structs, status and command codes and sizing constants; no dependencies
package sta_pkg;
	localparam int MEM_BYTES_DEF = 4096;
	localparam int SLOT_COUNT_DEF = 20;
	localparam int BND_W = 13;
	localparam int FLD_W = 14;
	localparam logic [BND_W-1:0] RESET_BOUNDARY = 13'd16;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_OOM = 2'd1;
	localparam logic [1:0] ST_BADADDR = 2'd2;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE = 1'b1;

	typedef struct packed {
		logic command;
		logic [15:0] request_size;
		logic [15:0] address;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [11:0] alloc_address;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture item, reset scan
		logic scan;      // examine one slot
		logic div_start; // start remainder unit
		logic div_step;  // one remainder iteration
		logic div_sel;   // 0: base mod g, 1: req mod g
		logic finish;    // decide and write back
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic is_free;
		logic early_done; // bad request or out of range free
		logic scan_hit;
		logic scan_last;
		logic div_done;
	} sts_t;
endpackage

/* rtl/sta_ctrl.sv */
// controller state machine for the slot table aligned allocator
// depends on sta_pkg
module sta_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input sta_pkg::sts_t sts,
	output sta_pkg::ctl_t ctl,
	output logic busy
);
	import sta_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CHK = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_DIVB = 3'd3;
	localparam logic [2:0] S_DIVR = 3'd4;
	localparam logic [2:0] S_FIN = 3'd5;

	logic [2:0] state_q, state_d;
	logic kick_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kick_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kick_q <= ctl.div_start;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				if (sts.early_done) state_d = S_FIN;
				else state_d = S_SCAN;
			end
			S_SCAN: begin
				ctl.scan = 1'b1;
				if (sts.scan_hit || sts.scan_last) begin
					if (sts.is_free || !sts.scan_hit) begin
						state_d = S_FIN;
					end else begin
						ctl.div_start = 1'b1;
						state_d = S_DIVB;
					end
				end
			end
			S_DIVB: begin
				ctl.div_step = !kick_q;
				if (!kick_q && sts.div_done) begin
					ctl.div_start = 1'b1;
					ctl.div_sel = 1'b1;
					state_d = S_DIVR;
				end
			end
			S_DIVR: begin
				ctl.div_sel = 1'b1;
				ctl.div_step = !kick_q;
				if (!kick_q && sts.div_done) state_d = S_FIN;
			end
			S_FIN: begin
				ctl.finish = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);
endmodule

/* rtl/sta_dp.sv */
// datapath for the slot table aligned allocator: slot table, scan, remainder unit
// depends on sta_pkg
module sta_dp #(
	parameter int MEM_BYTES = sta_pkg::MEM_BYTES_DEF,
	parameter int SLOT_COUNT = sta_pkg::SLOT_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [sta_pkg::BND_W-1:0] cfg_data,
	input sta_pkg::in_item_t in_item,
	input sta_pkg::ctl_t ctl,
	output sta_pkg::sts_t sts,
	output sta_pkg::out_item_t result,
	output logic result_valid
);
	import sta_pkg::*;

	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int SW = 17;
	localparam logic [IW-1:0] LAST = IW'(SLOT_COUNT - 1);
	localparam logic [16:0] MEMB = 17'(MEM_BYTES);

	logic [BND_W-1:0] boundary_q;
	logic [SLOT_COUNT-1:0] valid_q;
	logic [FLD_W-1:0] off_q [SLOT_COUNT];
	logic [FLD_W-1:0] size_q [SLOT_COUNT];

	logic cmd_q;
	logic [15:0] req_q, addr_q;
	logic [IW-1:0] idx_q;
	logic hit_q;
	logic [SW-1:0] base_q;
	logic [SW-1:0] rem_q, rb_q;
	logic [4:0] cnt_q;
	logic [SW-1:0] quo_dummy_q;

	logic [12:0] g;
	assign g = (boundary_q == '0) ? 13'd1 : boundary_q;

	logic cur_match;
	assign cur_match = cmd_q ? (valid_q[idx_q] && (off_q[idx_q] == addr_q[FLD_W-1:0])
		&& (addr_q[15:FLD_W] == '0)) : !valid_q[idx_q];

	assign sts.is_free = cmd_q;
	assign sts.early_done = cmd_q ? (17'(addr_q) >= MEMB)
		: (req_q == '0 || 17'(req_q) > MEMB);
	assign sts.scan_hit = cur_match;
	assign sts.scan_last = (idx_q == LAST);
	assign sts.div_done = (cnt_q == '0);

	// restoring remainder, one bit per cycle over 17 bits
	logic [SW-1:0] tr;
	logic [SW:0] sh;
	assign sh = {rem_q, quo_dummy_q[SW-1]};
	assign tr = (sh >= {5'd0, g}) ? SW'(sh - {5'd0, g}) : sh[SW-1:0];

	logic [SW-1:0] prev_end;
	always_comb begin
		if (idx_q == '0) prev_end = '0;
		else prev_end = SW'(off_q[idx_q - 1'b1]) + SW'(size_q[idx_q - 1'b1]);
	end

	logic [SW-1:0] abase, need;
	logic [SW:0] tot;
	assign abase = (rb_q == '0) ? base_q : SW'(base_q + SW'(g) - rb_q);
	assign need = SW'(17'(req_q) + SW'(g) - rem_q);
	assign tot = 18'(abase) + 18'(need);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boundary_q <= RESET_BOUNDARY;
			valid_q <= '0;
			result_valid <= 1'b0;
		end else begin
			if (cfg_we) boundary_q <= cfg_data;
			result_valid <= ctl.finish;
			if (ctl.finish && hit_q && !sts.early_done) begin
				if (cmd_q) begin
					valid_q[idx_q] <= 1'b0;
				end else if (tot <= 18'(MEMB)) begin
					valid_q[idx_q] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				off_q[i] <= '0;
				size_q[i] <= '0;
			end
		end else if (ctl.finish && hit_q && !sts.early_done) begin
			if (cmd_q) begin
				size_q[idx_q] <= '0;
			end else begin
				off_q[idx_q] <= abase[FLD_W-1:0];
				if (tot <= 18'(MEMB)) size_q[idx_q] <= need[FLD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= in_item.command;
			req_q <= in_item.request_size;
			addr_q <= in_item.address;
			idx_q <= '0;
			hit_q <= 1'b0;
		end else if (ctl.scan) begin
			if (cur_match) begin
				hit_q <= 1'b1;
				base_q <= prev_end;
			end else if (idx_q != LAST) begin
				idx_q <= idx_q + 1'b1;
			end
		end
		if (ctl.div_start) begin
			rem_q <= '0;
			cnt_q <= 5'(SW);
			quo_dummy_q <= ctl.div_sel ? 17'(req_q) : (ctl.scan ? prev_end : base_q);
		end else if (ctl.div_step && cnt_q != '0) begin
			rem_q <= tr;
			quo_dummy_q <= {quo_dummy_q[SW-2:0], 1'b0};
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == 5'd1 && !ctl.div_sel) rb_q <= tr;
		end
		if (ctl.finish) begin
			if (sts.early_done || !hit_q) begin
				result.status <= cmd_q ? ST_BADADDR : ST_OOM;
				result.alloc_address <= '0;
			end else if (cmd_q) begin
				result.status <= ST_OK;
				result.alloc_address <= '0;
			end else if (tot <= 18'(MEMB)) begin
				result.status <= ST_OK;
				result.alloc_address <= abase[11:0];
			end else begin
				result.status <= ST_OOM;
				result.alloc_address <= '0;
			end
		end
	end

`ifndef SYNTHESIS
	a_valid_one: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("result strobe held");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.div_step |-> (cnt_q <= 5'(SW))) else $error("remainder count out of range");
	a_ok_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status != ST_OK) |-> result.alloc_address == '0)
		else $error("address on failed item");
`endif
endmodule

/* rtl/slot_table_aligned_allocator.sv */
// top level of the slot table aligned allocator
// joins sta_ctrl and sta_dp; depends on sta_pkg
//
// sequence: a bad request or out of range free goes from the check straight to finish, a
//   free scans the slot table first, and an allocate that finds a free slot also runs
//   the 17-step bit-serial remainder unit twice (base mod g, then request mod g)
// throughput: one item at a time; busy drops as the result strobe rises, so the next item
//   is taken at the edge that ends the strobe
// reset: asynchronous, clears the slot table and sets boundary to 16; results cannot stall
module slot_table_aligned_allocator #(
	parameter int MEM_BYTES = sta_pkg::MEM_BYTES_DEF,
	parameter int SLOT_COUNT = sta_pkg::SLOT_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input sta_pkg::in_item_t in_item,
	input logic cfg_we,
	input logic [sta_pkg::BND_W-1:0] cfg_data,
	output logic result_valid,
	output sta_pkg::out_item_t result
);
	import sta_pkg::*;

	ctl_t ctl;
	sts_t sts;

	// controller sequences check, scan and the two remainders
	sta_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start),
		.sts(sts), .ctl(ctl), .busy(busy)
	);

	// datapath holds the table and the arithmetic
	sta_dp #(.MEM_BYTES(MEM_BYTES), .SLOT_COUNT(SLOT_COUNT)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_item(in_item), .ctl(ctl), .sts(sts),
		.result(result), .result_valid(result_valid)
	);
endmodule
